>>> hw/rtl/csp_pkg.sv
// Package for the CIGAR string parser: widths, item types and operation decode.
`timescale 1ns / 1ps

package csp_pkg;

  // Width of run lengths, running sums and result length fields
  localparam int CountBits = 28;
  localparam logic [CountBits-1:0] CountMax = {CountBits{1'b1}};

  // ASCII codes of the characters the parser understands
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChM     = 8'h4D;
  localparam logic [7:0] ChI     = 8'h49;
  localparam logic [7:0] ChD     = 8'h44;
  localparam logic [7:0] ChN     = 8'h4E;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChH     = 8'h48;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChEq    = 8'h3D;
  localparam logic [7:0] ChX     = 8'h58;

  // What an operation letter does with the pending run length
  typedef enum logic [2:0] {
    OP_BOTH,   // M, = and X: query and reference
    OP_QUERY,  // I
    OP_REF,    // D and N
    OP_CLIP,   // S and H
    OP_PAD,    // P: consumes nothing
    OP_BAD     // anything that is not an operation letter
  } op_kind_t;

  // One input character as held between the input and parse stages
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } item_t;

  function automatic op_kind_t decode_op(input logic [7:0] c);
    op_kind_t k;
    case (c)
      ChM, ChEq, ChX: k = OP_BOTH;
      ChI:            k = OP_QUERY;
      ChD, ChN:       k = OP_REF;
      ChS, ChH:       k = OP_CLIP;
      ChP:            k = OP_PAD;
      default:        k = OP_BAD;
    endcase
    return k;
  endfunction

  // Saturating add of two counts
  function automatic logic [CountBits-1:0] sat_add(input logic [CountBits-1:0] a,
                                                   input logic [CountBits-1:0] b);
    logic [CountBits:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CountBits] ? CountMax : s[CountBits-1:0];
  endfunction

endpackage

>>> hw/rtl/csp_if.sv
// Channel interfaces of the CIGAR string parser: character input and result output.
`timescale 1ns / 1ps

interface csp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

interface csp_out_if;
  logic                          valid;
  logic                          ready;
  logic [csp_pkg::CountBits-1:0] query_len;
  logic [csp_pkg::CountBits-1:0] ref_len;
  logic [csp_pkg::CountBits-1:0] clip_front;
  logic [csp_pkg::CountBits-1:0] clip_back;
  logic                          error;

  modport source (output valid, output query_len, output ref_len, output clip_front,
                  output clip_back, output error, input ready);
  modport sink (input valid, input query_len, input ref_len, input clip_front,
                input clip_back, input error, output ready);
endinterface

>>> hw/rtl/csp_in_stage.sv
// Input register of the CIGAR string parser: holds one character for the parse stage.
`timescale 1ns / 1ps

module csp_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  csp_in_if.sink         in_chan,
  input  logic           take,
  output logic           hold_valid,
  output csp_pkg::item_t hold_item
);

  logic           hold_valid_r, hold_valid_nxt;
  csp_pkg::item_t hold_item_r, hold_item_nxt;
  logic           in_xfer;

  // Free slot, or the held character leaves this cycle
  assign in_chan.ready = !hold_valid_r || take;
  assign in_xfer       = in_chan.valid && in_chan.ready;

  always_comb begin
    hold_valid_nxt = hold_valid_r;
    hold_item_nxt  = hold_item_r;
    if (in_xfer) begin
      hold_valid_nxt     = 1'b1;
      hold_item_nxt.ch   = in_chan.ch;
      hold_item_nxt.last = in_chan.last;
    end else if (take) begin
      hold_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    hold_item_r <= hold_item_nxt;
  end

  assign hold_valid = hold_valid_r;
  assign hold_item  = hold_item_r;

endmodule

>>> hw/rtl/csp_parse.sv
// Parse stage of the CIGAR string parser: run length, sums, clips and result register.
`timescale 1ns / 1ps

module csp_parse (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           hold_valid,
  input  csp_pkg::item_t hold_item,
  output logic           take,
  csp_out_if.source      out_chan
);

  localparam int W = csp_pkg::CountBits;

  logic [W-1:0] run_r, run_nxt;
  logic         have_r, have_nxt;
  logic [W-1:0] qsum_r, qsum_nxt;
  logic [W-1:0] rsum_r, rsum_nxt;
  logic [W-1:0] fclip_r, fclip_nxt;
  logic [W-1:0] bclip_r, bclip_nxt;
  logic         bad_r, bad_nxt;

  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] oq_r, oq_nxt;
  logic [W-1:0] or_r, or_nxt;
  logic [W-1:0] of_r, of_nxt;
  logic [W-1:0] ob_r, ob_nxt;
  logic         oerr_r, oerr_nxt;

  logic              is_digit;
  logic [3:0]        digit;
  logic [W+3:0]      mul_sum;
  logic [W-1:0]      run_dec;
  csp_pkg::op_kind_t kind;
  logic              fin_bad;

  // A character moves on unless it ends a text and the result slot is still full
  assign take = hold_valid && (!hold_item.last || !out_valid_r || out_chan.ready);

  // Decimal accumulate: run * 10 + digit, saturating
  assign is_digit = (hold_item.ch >= csp_pkg::ChZero) && (hold_item.ch <= csp_pkg::ChNine);
  assign digit    = 4'(hold_item.ch - csp_pkg::ChZero);
  assign mul_sum  = ({4'b0, run_r} << 3) + ({4'b0, run_r} << 1) + (W+4)'(digit);
  assign run_dec  = (mul_sum[W+3:W] != 4'b0) ? csp_pkg::CountMax : mul_sum[W-1:0];
  assign kind     = csp_pkg::decode_op(hold_item.ch);

  // One character step plus end-of-text result
  always_comb begin
    run_nxt   = run_r;
    have_nxt  = have_r;
    qsum_nxt  = qsum_r;
    rsum_nxt  = rsum_r;
    fclip_nxt = fclip_r;
    bclip_nxt = bclip_r;
    bad_nxt   = bad_r;
    fin_bad   = 1'b0;

    out_valid_nxt = out_valid_r && !out_chan.ready;
    oq_nxt   = oq_r;
    or_nxt   = or_r;
    of_nxt   = of_r;
    ob_nxt   = ob_r;
    oerr_nxt = oerr_r;

    if (take) begin
      if (!bad_r) begin
        if (is_digit) begin
          run_nxt  = run_dec;
          have_nxt = 1'b1;
        end else if (kind == csp_pkg::OP_BAD || !have_r) begin
          bad_nxt = 1'b1;
        end else begin
          case (kind)
            csp_pkg::OP_BOTH: begin
              qsum_nxt = csp_pkg::sat_add(qsum_r, run_r);
              rsum_nxt = csp_pkg::sat_add(rsum_r, run_r);
            end
            csp_pkg::OP_QUERY: qsum_nxt = csp_pkg::sat_add(qsum_r, run_r);
            csp_pkg::OP_REF:   rsum_nxt = csp_pkg::sat_add(rsum_r, run_r);
            csp_pkg::OP_CLIP: begin
              if (qsum_r == '0) begin
                fclip_nxt = run_r;
              end else begin
                bclip_nxt = run_r;
              end
            end
            default: ;
          endcase
          run_nxt  = '0;
          have_nxt = 1'b0;
        end
      end

      if (hold_item.last) begin
        // Digits left pending at the end also mark the text malformed
        fin_bad       = bad_nxt || have_nxt;
        out_valid_nxt = 1'b1;
        oq_nxt   = fin_bad ? '0 : qsum_nxt;
        or_nxt   = fin_bad ? '0 : rsum_nxt;
        of_nxt   = fin_bad ? '0 : fclip_nxt;
        ob_nxt   = fin_bad ? '0 : bclip_nxt;
        oerr_nxt = fin_bad;
        run_nxt   = '0;
        have_nxt  = 1'b0;
        qsum_nxt  = '0;
        rsum_nxt  = '0;
        fclip_nxt = '0;
        bclip_nxt = '0;
        bad_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= '0;
      have_r      <= 1'b0;
      qsum_r      <= '0;
      rsum_r      <= '0;
      fclip_r     <= '0;
      bclip_r     <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      run_r       <= run_nxt;
      have_r      <= have_nxt;
      qsum_r      <= qsum_nxt;
      rsum_r      <= rsum_nxt;
      fclip_r     <= fclip_nxt;
      bclip_r     <= bclip_nxt;
      bad_r       <= bad_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    oq_r   <= oq_nxt;
    or_r   <= or_nxt;
    of_r   <= of_nxt;
    ob_r   <= ob_nxt;
    oerr_r <= oerr_nxt;
  end

  assign out_chan.valid      = out_valid_r;
  assign out_chan.query_len  = oq_r;
  assign out_chan.ref_len    = or_r;
  assign out_chan.clip_front = of_r;
  assign out_chan.clip_back  = ob_r;
  assign out_chan.error      = oerr_r;

endmodule

>>> hw/rtl/cigar_string_parser_core.sv
// CIGAR string parser: counts query, reference and clip lengths of a SAM CIGAR text.
// Usage:
//   in_chan takes the CIGAR text one ASCII character per transfer, with last set on
//   the final character. out_chan gives one result per text: query length,
//   reference length, front and back clip, and an error flag (lengths zero on error).
//   Result: the last character passes the input register, then the parse step into
//   the result register. Throughput: one character per cycle, texts back to back,
//   while out_chan takes each result without delay; each character passes an input
//   register and one parse step into the state registers.
//   Stall: a result waits in the output register while out_chan.ready is low; the
//   input register keeps taking characters until the last character of the next
//   text reaches the parse stage, then in_chan.ready drops until the result leaves.
//   Reset: synchronous, active low; clears all parse state and both valid flags,
//   so the first character after reset starts a new text.
`timescale 1ns / 1ps

module cigar_string_parser_core (
  input  logic      clk,
  input  logic      rst_n,
  csp_in_if.sink    in_chan,
  csp_out_if.source out_chan
);

  logic           take;
  logic           hold_valid;
  csp_pkg::item_t hold_item;

  csp_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .take       (take),
    .hold_valid (hold_valid),
    .hold_item  (hold_item)
  );

  csp_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .hold_valid (hold_valid),
    .hold_item  (hold_item),
    .take       (take),
    .out_chan   (out_chan)
  );

endmodule

>>> bench/cigar_string_parser_core_tb.sv
// Self-checking testbench for the CIGAR string parser core.
`timescale 1ns / 1ps

module cigar_string_parser_core_tb;

  localparam int IdleLimit   = 2000;  // cycles with no transfer on either channel
  localparam int RandomChars = 800;
  localparam int PrintCap    = 40;

  // One result of a parsed CIGAR text
  typedef struct packed {
    logic [csp_pkg::CountBits-1:0] query_len;
    logic [csp_pkg::CountBits-1:0] ref_len;
    logic [csp_pkg::CountBits-1:0] clip_front;
    logic [csp_pkg::CountBits-1:0] clip_back;
    logic                          error;
  } cigar_totals_t;

  // Tracks the text being parsed and holds the totals still owed by the block
  class cigar_scoreboard;
    logic [csp_pkg::CountBits-1:0] pend_run;
    logic                          pend_digits;
    logic [csp_pkg::CountBits-1:0] q_sum;
    logic [csp_pkg::CountBits-1:0] r_sum;
    logic [csp_pkg::CountBits-1:0] front;
    logic [csp_pkg::CountBits-1:0] back;
    logic                          malformed;
    cigar_totals_t                 owed_q[$];
    int unsigned                   mismatches;
    int unsigned                   texts;
    int unsigned                   bad_texts;
    int unsigned                   sat_texts;
    int unsigned                   chars;

    function new();
      restart();
      mismatches = 0;
      texts      = 0;
      bad_texts  = 0;
      sat_texts  = 0;
      chars      = 0;
    endfunction

    function void restart();
      pend_run    = '0;
      pend_digits = 1'b0;
      q_sum       = '0;
      r_sum       = '0;
      front       = '0;
      back        = '0;
      malformed   = 1'b0;
    endfunction

    function logic [csp_pkg::CountBits-1:0] clamp(input longint unsigned v);
      logic [csp_pkg::CountBits-1:0] r;
      if (v > 64'(csp_pkg::CountMax)) r = csp_pkg::CountMax;
      else r = v[csp_pkg::CountBits-1:0];
      return r;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    // Advance the text state by one accepted character
    function void note_input(input logic [7:0] c, input logic lst);
      csp_pkg::op_kind_t kind;
      cigar_totals_t     t;
      chars++;
      if (!malformed) begin
        if (c >= csp_pkg::ChZero && c <= csp_pkg::ChNine) begin
          pend_run    = clamp(64'(pend_run) * 64'd10 + 64'(c - csp_pkg::ChZero));
          pend_digits = 1'b1;
        end else begin
          case (c)
            csp_pkg::ChM, csp_pkg::ChEq, csp_pkg::ChX: kind = csp_pkg::OP_BOTH;
            csp_pkg::ChI:                              kind = csp_pkg::OP_QUERY;
            csp_pkg::ChD, csp_pkg::ChN:                kind = csp_pkg::OP_REF;
            csp_pkg::ChS, csp_pkg::ChH:                kind = csp_pkg::OP_CLIP;
            csp_pkg::ChP:                              kind = csp_pkg::OP_PAD;
            default:                                   kind = csp_pkg::OP_BAD;
          endcase
          if (kind == csp_pkg::OP_BAD || !pend_digits) begin
            malformed = 1'b1;
          end else begin
            // clip slot depends on query consumed so far, before this op
            if (kind == csp_pkg::OP_CLIP) begin
              if (q_sum == '0) front = pend_run;
              else back = pend_run;
            end
            if (kind == csp_pkg::OP_BOTH || kind == csp_pkg::OP_QUERY)
              q_sum = clamp(64'(q_sum) + 64'(pend_run));
            if (kind == csp_pkg::OP_BOTH || kind == csp_pkg::OP_REF)
              r_sum = clamp(64'(r_sum) + 64'(pend_run));
            pend_run    = '0;
            pend_digits = 1'b0;
          end
        end
      end
      if (lst) begin
        if (pend_digits) malformed = 1'b1;
        if (malformed) begin
          t = '{query_len: '0, ref_len: '0, clip_front: '0, clip_back: '0, error: 1'b1};
          bad_texts++;
        end else begin
          t = '{query_len: q_sum, ref_len: r_sum, clip_front: front, clip_back: back,
                error: 1'b0};
          if (q_sum == csp_pkg::CountMax || r_sum == csp_pkg::CountMax ||
              front == csp_pkg::CountMax || back == csp_pkg::CountMax) sat_texts++;
        end
        owed_q.push_back(t);
        texts++;
        restart();
      end
    endfunction

    task report(input string msg);
      if (mismatches < PrintCap) $display("[%0t] check failed: %s", $time, msg);
      mismatches++;
    endtask

    // Compare one result transfer with the oldest owed totals
    task check_result(input cigar_totals_t got);
      cigar_totals_t w;
      if (owed_q.size() == 0) begin
        report("result with no text outstanding");
      end else begin
        w = owed_q.pop_front();
        if (got.query_len != w.query_len)
          report($sformatf("query_len %0d, want %0d", got.query_len, w.query_len));
        if (got.ref_len != w.ref_len)
          report($sformatf("ref_len %0d, want %0d", got.ref_len, w.ref_len));
        if (got.clip_front != w.clip_front)
          report($sformatf("clip_front %0d, want %0d", got.clip_front, w.clip_front));
        if (got.clip_back != w.clip_back)
          report($sformatf("clip_back %0d, want %0d", got.clip_back, w.clip_back));
        if (got.error != w.error)
          report($sformatf("error %0b, want %0b", got.error, w.error));
      end
    endtask
  endclass

  logic clk;
  logic rst_n;

  csp_in_if  in_chan ();
  csp_out_if out_chan ();

  cigar_string_parser_core dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  cigar_scoreboard sb = new();
  cigar_totals_t   seen;
  logic [7:0]      text_q[$];
  int              burst_left;
  int              idle_cycles;
  logic [15:0]     rx_pat;
  int              rx_mode;
  int              rx_left;
  int              hold_left;
  logic            hold_val;
  logic [7:0]      op_set[9];

  // Clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Monitor: note input transfers, check result transfers
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_chan.valid && in_chan.ready) sb.note_input(in_chan.ch, in_chan.last);
      if (out_chan.valid && out_chan.ready) begin
        seen = '{query_len: out_chan.query_len, ref_len: out_chan.ref_len,
                 clip_front: out_chan.clip_front, clip_back: out_chan.clip_back,
                 error: out_chan.error};
        sb.check_result(seen);
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("timeout: no transfer for %0d cycles, %0d results owed",
               IdleLimit, sb.pending());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Result-side backpressure: phases of always-ready, a rotating pattern, or runs of random length
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 120);
      rx_pat  = 16'($urandom) | 16'h1;
    end
    rx_left--;
    case (rx_mode)
      0: out_chan.ready <= 1'b1;
      1: begin
        out_chan.ready <= rx_pat[0];
        rx_pat = {rx_pat[0], rx_pat[15:1]};
      end
      default: begin
        if (hold_left == 0) begin
          hold_val  = ~hold_val;
          hold_left = $urandom_range(1, 12);
        end
        hold_left--;
        out_chan.ready <= hold_val;
      end
    endcase
  end

  // Drive one character; the sender runs in bursts with random gaps between them
  task automatic send_char(input logic [7:0] c, input logic lst);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_chan.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk);
    in_chan.valid <= 1'b1;
    in_chan.ch    <= c;
    in_chan.last  <= lst;
    do @(posedge clk); while (!in_chan.ready);
    burst_left--;
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  // Hold the sender until the block has returned every owed result
  task automatic drain();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic add_num(input int unsigned n);
    string s;
    s = $sformatf("%0d", n);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  task automatic add_op(input int unsigned n, input logic [7:0] op);
    add_num(n);
    text_q.push_back(op);
  endtask

  // Decimal run length: mostly short, some mid-size, a few long ones that may pass the count range
  task automatic add_rand_digits();
    int nd;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 7) nd = $urandom_range(1, 2);
    else if (pick < 9) nd = $urandom_range(3, 5);
    else nd = $urandom_range(8, 10);
    repeat (nd) text_q.push_back(csp_pkg::ChZero + 8'($urandom_range(0, 9)));
  endtask

  // Random text: mostly well-formed, some corrupted, some pure noise
  task automatic make_text();
    int kind;
    int nops;
    int pos;
    logic [7:0] op;
    kind = $urandom_range(0, 99);
    if (kind >= 90) begin
      repeat ($urandom_range(1, 8)) text_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      nops = $urandom_range(1, 6);
      for (int i = 0; i < nops; i++) begin
        add_rand_digits();
        if ((i == 0 || i == nops - 1) && $urandom_range(0, 3) == 0)
          op = ($urandom_range(0, 1) == 0) ? csp_pkg::ChS : csp_pkg::ChH;
        else
          op = op_set[$urandom_range(0, 8)];
        text_q.push_back(op);
      end
      if (kind >= 75) begin
        pos = $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 2))
          0: text_q[pos] = 8'($urandom_range(0, 255));       // stray byte
          1: text_q.insert(pos, op_set[$urandom_range(0, 8)]); // letter may lack a number
          default: add_rand_digits();                          // text ends in digits
        endcase
      end
    end
  endtask

  initial begin
    op_set = '{csp_pkg::ChM, csp_pkg::ChI, csp_pkg::ChD, csp_pkg::ChN, csp_pkg::ChS,
               csp_pkg::ChH, csp_pkg::ChP, csp_pkg::ChEq, csp_pkg::ChX};
    rst_n          = 1'b0;
    in_chan.valid  = 1'b0;
    in_chan.ch     = '0;
    in_chan.last   = 1'b0;
    out_chan.ready = 1'b0;
    burst_left     = 0;
    idle_cycles    = 0;
    rx_left        = 0;
    hold_left      = 0;
    hold_val       = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Every operation; clip after a zero-length op stays in front, later clip goes back
    add_op(1, csp_pkg::ChS); add_op(0, csp_pkg::ChM); add_op(2, csp_pkg::ChH);
    add_op(3, csp_pkg::ChI); add_op(4, csp_pkg::ChD); add_op(5, csp_pkg::ChN);
    add_op(6, csp_pkg::ChP); add_op(7, csp_pkg::ChEq); add_op(8, csp_pkg::ChX);
    add_op(9, csp_pkg::ChS);
    send_text();
    // Letter with no run length
    text_q.push_back(csp_pkg::ChM);
    send_text();
    // Text that ends in digits
    text_q.push_back(csp_pkg::ChZero + 8'd7);
    send_text();
    // Bad byte at the top of the range, then a bad byte of zero alone
    add_op(3, csp_pkg::ChM);
    text_q.push_back(8'hFF);
    send_text();
    text_q.push_back(8'h00);
    send_text();
    // Run length past the count range
    repeat (9) text_q.push_back(csp_pkg::ChNine);
    text_q.push_back(csp_pkg::ChM);
    send_text();
    drain();

    // Random texts, with a full drain after each text that ends near the midway character count
    while (sb.chars < 36 + RandomChars) begin
      make_text();
      send_text();
      if (sb.chars >= 36 + RandomChars / 2 && sb.chars < 36 + RandomChars / 2 + 12)
        drain();
    end

    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Parsed %0d texts over %0d characters: %0d malformed, %0d with a saturated length.",
             sb.texts, sb.chars, sb.bad_texts, sb.sat_texts);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("%0d field mismatches", sb.mismatches);
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

>>> cigar_string_parser_core.f
hw/rtl/csp_pkg.sv
hw/rtl/csp_if.sv
hw/rtl/csp_in_stage.sv
hw/rtl/csp_parse.sv
hw/rtl/cigar_string_parser_core.sv
bench/cigar_string_parser_core_tb.sv
